FILE: design/rbeu_pkg.sv
// Shared constants, opcodes, fault codes and divider types for the register bytecode execute unit.
package rbeu_pkg;

  localparam int unsigned STACK_DEPTH_DEF = 1024;
  localparam int unsigned CALL_DEPTH_DEF  = 64;
  localparam int unsigned FRAME_DEPTH_DEF = 64;
  localparam int unsigned INSN_BYTES      = 8;
  localparam int unsigned PC_W            = 24;
  localparam int unsigned DATA_W          = 32;
  localparam int unsigned REG_W           = 8;

  // Opcodes
  localparam logic [4:0] OP_HALT  = 5'd0;
  localparam logic [4:0] OP_MOVI  = 5'd1;
  localparam logic [4:0] OP_MOV   = 5'd3;
  localparam logic [4:0] OP_ADD   = 5'd4;
  localparam logic [4:0] OP_SUB   = 5'd5;
  localparam logic [4:0] OP_MUL   = 5'd6;
  localparam logic [4:0] OP_DIV   = 5'd7;
  localparam logic [4:0] OP_MOD   = 5'd8;
  localparam logic [4:0] OP_EQ    = 5'd9;
  localparam logic [4:0] OP_NE    = 5'd10;
  localparam logic [4:0] OP_LT    = 5'd11;
  localparam logic [4:0] OP_GT    = 5'd12;
  localparam logic [4:0] OP_JMP   = 5'd13;
  localparam logic [4:0] OP_JIF   = 5'd14;
  localparam logic [4:0] OP_PUSH  = 5'd15;
  localparam logic [4:0] OP_CALL  = 5'd16;
  localparam logic [4:0] OP_RET   = 5'd17;
  localparam logic [4:0] OP_SHOW  = 5'd18;
  localparam logic [4:0] OP_LE    = 5'd19;
  localparam logic [4:0] OP_GE    = 5'd20;

  // Fault codes
  localparam logic [2:0] F_NONE  = 3'd0;
  localparam logic [2:0] F_DIV0  = 3'd1;
  localparam logic [2:0] F_UNSUP = 3'd2;
  localparam logic [2:0] F_OVER  = 3'd3;
  localparam logic [2:0] F_UNDER = 3'd4;

  // Divider request / response
  typedef struct packed {
    logic        start;
    logic        is_mod;
    logic [31:0] a;
    logic [31:0] b;
  } div_req_t;

  typedef struct packed {
    logic        done;
    logic [31:0] res;
  } div_rsp_t;

endpackage

FILE: design/rbeu_div.sv
// Radix-2 signed divider, one quotient bit per cycle.
module rbeu_div (
  input  logic               clk,
  input  logic               rst_n,
  input  rbeu_pkg::div_req_t req,
  output rbeu_pkg::div_rsp_t rsp
);
  import rbeu_pkg::*;

  logic [31:0] rem_r, rem_nxt;
  logic [31:0] quo_r, quo_nxt;
  logic [31:0] dvs_r, dvs_nxt;
  logic [5:0]  cnt_r, cnt_nxt;
  logic        busy_r, busy_nxt;
  logic        neg_q_r, neg_q_nxt, neg_r_r, neg_r_nxt, mod_r, mod_nxt;
  logic        done_r, done_nxt;
  logic [32:0] trial;
  logic [31:0] shl_rem;
  logic [31:0] abs_a, abs_b, q_fix, r_fix;

  assign abs_a   = req.a[31] ? (~req.a + 32'd1) : req.a;
  assign abs_b   = req.b[31] ? (~req.b + 32'd1) : req.b;
  assign shl_rem = {rem_r[30:0], quo_r[31]};
  assign trial   = {1'b0, shl_rem} - {1'b0, dvs_r};
  assign q_fix   = neg_q_r ? (~quo_r + 32'd1) : quo_r;
  assign r_fix   = neg_r_r ? (~rem_r + 32'd1) : rem_r;

  // Restoring division step
  always_comb begin
    rem_nxt   = rem_r;
    quo_nxt   = quo_r;
    dvs_nxt   = dvs_r;
    cnt_nxt   = cnt_r;
    busy_nxt  = busy_r;
    neg_q_nxt = neg_q_r;
    neg_r_nxt = neg_r_r;
    mod_nxt   = mod_r;
    done_nxt  = 1'b0;
    if (req.start) begin
      rem_nxt   = '0;
      quo_nxt   = abs_a;
      dvs_nxt   = abs_b;
      cnt_nxt   = 6'd32;
      busy_nxt  = 1'b1;
      neg_q_nxt = req.a[31] ^ req.b[31];
      neg_r_nxt = req.a[31];
      mod_nxt   = req.is_mod;
    end else if (busy_r) begin
      if (trial[32]) begin
        rem_nxt = shl_rem;
        quo_nxt = {quo_r[30:0], 1'b0};
      end else begin
        rem_nxt = trial[31:0];
        quo_nxt = {quo_r[30:0], 1'b1};
      end
      cnt_nxt = cnt_r - 6'd1;
      if (cnt_r == 6'd1) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
    rem_r   <= rem_nxt;
    quo_r   <= quo_nxt;
    dvs_r   <= dvs_nxt;
    neg_q_r <= neg_q_nxt;
    neg_r_r <= neg_r_nxt;
    mod_r   <= mod_nxt;
  end

  assign rsp.done = done_r;
  assign rsp.res  = mod_r ? r_fix : q_fix;
endmodule

FILE: design/rbeu_ctl.sv
// Instruction sequencer: reads and writes the value, frame-base and return stacks.
module rbeu_ctl #(
  parameter int unsigned STACK_DEPTH = rbeu_pkg::STACK_DEPTH_DEF,
  parameter int unsigned CALL_DEPTH  = rbeu_pkg::CALL_DEPTH_DEF,
  parameter int unsigned FRAME_DEPTH = rbeu_pkg::FRAME_DEPTH_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_tvalid,
  output logic               in_tready,
  input  logic [135:0]       in_tdata,
  output logic               out_tvalid,
  input  logic               out_tready,
  output logic [63:0]        out_tdata,
  output rbeu_pkg::div_req_t div_req,
  input  rbeu_pkg::div_rsp_t div_rsp
);
  import rbeu_pkg::*;

  localparam int unsigned SA_W = $clog2(STACK_DEPTH);
  localparam int unsigned ST_W = SA_W + 1;            // signed top, -1 = empty
  localparam int unsigned CA_W = $clog2(CALL_DEPTH);
  localparam int unsigned CC_W = CA_W + 1;
  localparam int unsigned FA_W = $clog2(FRAME_DEPTH);
  localparam int unsigned FC_W = FA_W + 1;
  localparam int unsigned WS_W = SA_W + 10;           // wide enough for sums

  localparam logic [3:0] S_IDLE  = 4'd0;
  localparam logic [3:0] S_RDA   = 4'd1;
  localparam logic [3:0] S_RDB   = 4'd2;
  localparam logic [3:0] S_EXEC  = 4'd3;
  localparam logic [3:0] S_DIV   = 4'd4;
  localparam logic [3:0] S_CLR   = 4'd5;
  localparam logic [3:0] S_RET0  = 4'd6;
  localparam logic [3:0] S_RET1  = 4'd7;
  localparam logic [3:0] S_OUT   = 4'd8;
  localparam logic [3:0] S_MUL   = 4'd9;

  // Memories
  logic [DATA_W-1:0] vstk_mem [STACK_DEPTH];
  logic [SA_W-1:0]   fbase_mem [FRAME_DEPTH];
  logic [PC_W-1:0]   rstk_mem [CALL_DEPTH];

  logic [3:0]        state_r, state_nxt;
  logic [4:0]        op_r;
  logic [REG_W-1:0]  rd_r, ra_r, rb_r, pcnt_r, rcnt_r;
  logic [31:0]       offs_r, cval_r;
  logic [PC_W-1:0]   entry_r;
  logic [PC_W-1:0]   pc_r, pc_nxt;
  logic signed [ST_W-1:0] top_r, top_nxt;
  logic [SA_W-1:0]   fp_r, fp_nxt;
  logic [FC_W-1:0]   fdep_r, fdep_nxt;
  logic [CC_W-1:0]   cdep_r, cdep_nxt;
  logic [DATA_W-1:0] a_r, a_nxt, b_r, b_nxt;
  logic [DATA_W-1:0] prod_r;
  logic [SA_W-1:0]   clr_r, clr_nxt, clr_end_r, clr_end_nxt;
  logic              clr_any_r, clr_any_nxt;
  logic [63:0]       res_r, res_nxt;

  // Memory port controls
  logic              v_we, v_re;
  logic [SA_W-1:0]   v_waddr, v_raddr;
  logic [DATA_W-1:0] v_wdata, v_rdata_r;
  logic              f_we;
  logic [FA_W-1:0]   f_waddr, f_raddr;
  logic [SA_W-1:0]   f_rdata_r;
  logic              r_we;
  logic [CA_W-1:0]   r_waddr, r_raddr;
  logic [PC_W-1:0]   r_rdata_r;

  logic [PC_W-1:0]   seq, jtgt;
  logic [WS_W-1:0]   ad_d, ad_a, ad_b;
  logic              ok_d, ok_a, ok_b;
  logic signed [ST_W+1:0] nfp;
  logic signed [ST_W+1:0] ntop;
  logic [DATA_W-1:0] alu_res;
  logic              is_alu;

  always_ff @(posedge clk) begin
    if (v_we) vstk_mem[v_waddr] <= v_wdata;
    if (v_re) v_rdata_r <= vstk_mem[v_raddr];
    if (f_we) fbase_mem[f_waddr] <= fp_nxt;
    f_rdata_r <= fbase_mem[f_raddr];
    if (r_we) rstk_mem[r_waddr] <= seq;
    r_rdata_r <= rstk_mem[r_raddr];
  end

  assign seq  = pc_r + PC_W'(INSN_BYTES);
  assign jtgt = seq + offs_r[PC_W-1:0];
  assign ad_d = WS_W'(fp_r) + WS_W'(rd_r);
  assign ad_a = WS_W'(fp_r) + WS_W'(ra_r);
  assign ad_b = WS_W'(fp_r) + WS_W'(rb_r);
  assign ok_d = ad_d < WS_W'(STACK_DEPTH);
  assign ok_a = ad_a < WS_W'(STACK_DEPTH);
  assign ok_b = ad_b < WS_W'(STACK_DEPTH);
  assign nfp  = (ST_W+2)'(top_r) - $signed({2'b00, ST_W'(pcnt_r)});
  assign ntop = nfp + $signed({2'b00, ST_W'(rcnt_r)}) - (ST_W+2)'(1);
  assign is_alu = (op_r >= OP_ADD && op_r <= OP_GT) || op_r == OP_LE || op_r == OP_GE;

  // Compare and simple arithmetic
  always_comb begin
    case (op_r)
      OP_ADD:  alu_res = a_r + b_r;
      OP_SUB:  alu_res = a_r - b_r;
      OP_MUL:  alu_res = prod_r;
      OP_EQ:   alu_res = {31'd0, a_r == b_r};
      OP_NE:   alu_res = {31'd0, a_r != b_r};
      OP_LT:   alu_res = {31'd0, $signed(a_r) <  $signed(b_r)};
      OP_GT:   alu_res = {31'd0, $signed(a_r) >  $signed(b_r)};
      OP_LE:   alu_res = {31'd0, $signed(a_r) <= $signed(b_r)};
      default: alu_res = {31'd0, $signed(a_r) >= $signed(b_r)};
    endcase
  end

  // Sequencer
  always_comb begin
    state_nxt   = state_r;
    pc_nxt      = pc_r;
    top_nxt     = top_r;
    fp_nxt      = fp_r;
    fdep_nxt    = fdep_r;
    cdep_nxt    = cdep_r;
    a_nxt       = a_r;
    b_nxt       = b_r;
    clr_nxt     = clr_r;
    clr_end_nxt = clr_end_r;
    clr_any_nxt = clr_any_r;
    res_nxt     = res_r;
    v_we = 1'b0; v_waddr = ad_d[SA_W-1:0]; v_wdata = alu_res;
    v_re = 1'b0; v_raddr = ad_a[SA_W-1:0];
    f_we = 1'b0; f_waddr = fdep_r[FA_W-1:0];
    f_raddr = FA_W'(fdep_r - FC_W'(2));
    r_we = 1'b0; r_waddr = cdep_r[CA_W-1:0];
    r_raddr = CA_W'(cdep_r - CC_W'(1));
    div_req = '0;
    div_req.a = a_r;
    div_req.b = b_r;
    div_req.is_mod = (op_r == OP_MOD);
    in_tready = (state_r == S_IDLE);

    case (state_r)
      S_IDLE: begin
        if (in_tvalid) state_nxt = S_RDA;
      end
      // issue operand A read (or handle non-reading ops)
      S_RDA: begin
        res_nxt = {3'd0, F_NONE, 32'd0, 2'b00, seq};
        case (op_r)
          OP_HALT: begin
            res_nxt = {3'd0, F_NONE, 32'd0, 2'b01, pc_r};
            state_nxt = S_OUT;
          end
          OP_MOVI: begin
            if (!ok_d) res_nxt = {3'd0, F_OVER, 32'd0, 2'b00, pc_r};
            else begin
              v_we = 1'b1; v_wdata = cval_r; pc_nxt = seq;
            end
            state_nxt = S_OUT;
          end
          OP_JMP: begin
            res_nxt = {3'd0, F_NONE, 32'd0, 2'b00, jtgt};
            pc_nxt = jtgt;
            state_nxt = S_OUT;
          end
          OP_CALL: begin
            if (nfp < 0) begin
              res_nxt = {3'd0, F_UNDER, 32'd0, 2'b00, pc_r};
              state_nxt = S_OUT;
            end else if (fdep_r >= FC_W'(FRAME_DEPTH) || cdep_r >= CC_W'(CALL_DEPTH)
                         || ntop >= $signed((ST_W+2)'(STACK_DEPTH))) begin
              res_nxt = {3'd0, F_OVER, 32'd0, 2'b00, pc_r};
              state_nxt = S_OUT;
            end else begin
              fp_nxt   = SA_W'(nfp);
              f_we     = 1'b1;
              fdep_nxt = fdep_r + FC_W'(1);
              r_we     = 1'b1;
              cdep_nxt = cdep_r + CC_W'(1);
              top_nxt  = ST_W'(ntop);
              clr_nxt     = SA_W'(nfp + $signed({2'b00, ST_W'(pcnt_r)}) + (ST_W+2)'(1));
              clr_end_nxt = SA_W'(ntop);
              clr_any_nxt = (nfp + $signed({2'b00, ST_W'(pcnt_r)}) + (ST_W+2)'(1)) <= ntop;
              res_nxt = {3'd0, F_NONE, 32'd0, 2'b00, entry_r};
              pc_nxt = entry_r;
              state_nxt = S_CLR;
            end
          end
          OP_RET: begin
            if (fdep_r == '0 || cdep_r == '0) begin
              res_nxt = {3'd0, F_UNDER, 32'd0, 2'b00, pc_r};
              state_nxt = S_OUT;
            end else begin
              v_re = 1'b1; v_raddr = fp_r;
              state_nxt = S_RET0;
            end
          end
          OP_MOV, OP_JIF, OP_SHOW: begin
            if (!ok_a || (op_r == OP_MOV && !ok_d)) begin
              res_nxt = {3'd0, F_OVER, 32'd0, 2'b00, pc_r};
              state_nxt = S_OUT;
            end else begin
              v_re = 1'b1; state_nxt = S_EXEC;
            end
          end
          OP_PUSH: begin
            if (!ok_a || top_r >= $signed(ST_W'(STACK_DEPTH - 1))) begin
              res_nxt = {3'd0, F_OVER, 32'd0, 2'b00, pc_r};
              state_nxt = S_OUT;
            end else begin
              v_re = 1'b1; state_nxt = S_EXEC;
            end
          end
          default: begin
            if (is_alu) begin
              if (!ok_a || !ok_b || !ok_d) begin
                res_nxt = {3'd0, F_OVER, 32'd0, 2'b00, pc_r};
                state_nxt = S_OUT;
              end else begin
                v_re = 1'b1; state_nxt = S_RDB;
              end
            end else begin
              res_nxt = {3'd0, F_UNSUP, 32'd0, 2'b00, pc_r};
              state_nxt = S_OUT;
            end
          end
        endcase
      end
      // A arrives, issue B read
      S_RDB: begin
        a_nxt = v_rdata_r;
        v_re = 1'b1; v_raddr = ad_b[SA_W-1:0];
        state_nxt = S_MUL;
      end
      S_MUL: begin
        b_nxt = v_rdata_r;
        state_nxt = S_EXEC;
      end
      // single-operand ops finish here; ALU ops latch B already
      S_EXEC: begin
        if (is_alu) begin
          if ((op_r == OP_DIV || op_r == OP_MOD) && b_r == '0) begin
            res_nxt = {3'd0, F_DIV0, 32'd0, 2'b00, pc_r};
            state_nxt = S_OUT;
          end else if (op_r == OP_DIV || op_r == OP_MOD) begin
            div_req.start = 1'b1;
            state_nxt = S_DIV;
          end else begin
            v_we = 1'b1; pc_nxt = seq; state_nxt = S_OUT;
          end
        end else begin
          case (op_r)
            OP_MOV: begin
              v_we = 1'b1; v_wdata = v_rdata_r; pc_nxt = seq;
            end
            OP_JIF: begin
              if (v_rdata_r == '0) begin
                res_nxt = {3'd0, F_NONE, 32'd0, 2'b00, jtgt};
                pc_nxt = jtgt;
              end else pc_nxt = seq;
            end
            OP_PUSH: begin
              top_nxt = top_r + ST_W'(1);
              v_we = 1'b1; v_waddr = SA_W'(top_nxt); v_wdata = v_rdata_r;
              pc_nxt = seq;
            end
            default: begin
              res_nxt = {3'd0, F_NONE, v_rdata_r, 2'b10, seq};
              pc_nxt = seq;
            end
          endcase
          state_nxt = S_OUT;
        end
      end
      S_DIV: begin
        if (div_rsp.done) begin
          v_we = 1'b1; v_wdata = div_rsp.res; pc_nxt = seq;
          state_nxt = S_OUT;
        end
      end
      // zero the callee's spare registers, one per cycle
      S_CLR: begin
        if (!clr_any_r) state_nxt = S_OUT;
        else begin
          v_we = 1'b1; v_waddr = clr_r; v_wdata = '0;
          clr_nxt = clr_r + SA_W'(1);
          if (clr_r == clr_end_r) state_nxt = S_OUT;
        end
      end
      // return: rv arrives, frame base and return address read
      S_RET0: begin
        a_nxt   = v_rdata_r;
        top_nxt = ST_W'({1'b0, fp_r}) - ST_W'(1);
        state_nxt = S_RET1;
      end
      S_RET1: begin
        fdep_nxt = fdep_r - FC_W'(1);
        cdep_nxt = cdep_r - CC_W'(1);
        fp_nxt   = (fdep_r > FC_W'(1)) ? f_rdata_r : '0;
        v_we = 1'b1; v_waddr = fp_nxt; v_wdata = a_r;
        res_nxt = {3'd0, F_NONE, 32'd0, 2'b00, r_rdata_r};
        pc_nxt  = r_rdata_r;
        state_nxt = S_OUT;
      end
      S_OUT: begin
        if (out_tready) state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      pc_r    <= '0;
      top_r   <= '1;
      fp_r    <= '0;
      fdep_r  <= '0;
      cdep_r  <= '0;
    end else begin
      state_r <= state_nxt;
      pc_r    <= pc_nxt;
      top_r   <= top_nxt;
      fp_r    <= fp_nxt;
      fdep_r  <= fdep_nxt;
      cdep_r  <= cdep_nxt;
    end
    if (in_tvalid && in_tready) begin
      op_r    <= in_tdata[4:0];
      rd_r    <= in_tdata[12:5];
      ra_r    <= in_tdata[20:13];
      rb_r    <= in_tdata[28:21];
      offs_r  <= in_tdata[60:29];
      cval_r  <= in_tdata[92:61];
      pcnt_r  <= in_tdata[100:93];
      rcnt_r  <= in_tdata[108:101];
      entry_r <= in_tdata[132:109];
    end
    a_r       <= a_nxt;
    b_r       <= b_nxt;
    prod_r    <= a_r * v_rdata_r;
    clr_r     <= clr_nxt;
    clr_end_r <= clr_end_nxt;
    clr_any_r <= clr_any_nxt;
    res_r     <= res_nxt;
  end

  assign out_tvalid = (state_r == S_OUT);
  assign out_tdata  = res_r;
endmodule

FILE: design/register_bytecode_execute_unit.sv
// Top level of the register bytecode execute unit.
// Executes one instruction per input transaction and returns one result
// transaction. The unit works on one instruction at a time: simple ops go
// through the value-stack memory (one read per operand, one write back),
// divide and modulo wait for the bit-serial divider, and call zeroes the
// callee's spare registers in turn.
// The value, frame-base and return stacks are memories with no reset; the
// pointers and depth counters reset to empty.
module register_bytecode_execute_unit #(
  parameter int unsigned STACK_DEPTH = rbeu_pkg::STACK_DEPTH_DEF,
  parameter int unsigned CALL_DEPTH  = rbeu_pkg::CALL_DEPTH_DEF,
  parameter int unsigned FRAME_DEPTH = rbeu_pkg::FRAME_DEPTH_DEF
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_tvalid,
  output logic         in_tready,
  // action, dest_reg, src_a, src_b, offset, const_value, callee_params,
  // callee_regs, callee_entry
  input  logic [135:0] in_tdata,
  output logic         out_tvalid,
  input  logic         out_tready,
  // next_pc, halted, print_valid, print_value, fault
  output logic [63:0]  out_tdata
);
  import rbeu_pkg::*;

  div_req_t div_req;
  div_rsp_t div_rsp;

  rbeu_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (div_req),
    .rsp   (div_rsp)
  );

  rbeu_ctl #(
    .STACK_DEPTH (STACK_DEPTH),
    .CALL_DEPTH  (CALL_DEPTH),
    .FRAME_DEPTH (FRAME_DEPTH)
  ) u_ctl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .div_req    (div_req),
    .div_rsp    (div_rsp)
  );
endmodule
